@@ design/lfs_pkg.sv @@
// Shared types, constants and codes for the line fit straightness block.
package lfs_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int COORD_BITS_DEF  = 20;
    localparam int WORD_W          = 64;
    localparam int DIV_FB_W        = 5;
    localparam int DIV_FB_SLOPE    = 16;
    localparam int DIV_FB_DIST     = 8;
    localparam int DIV_EXT_W       = WORD_W + 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE, OP_MUL_NSXY, OP_MUL_SXSY, OP_MUL_NSXX, OP_MUL_SXSX, OP_DIV_K,
        OP_MUL_KK, OP_SQRT, OP_MUL_DEN, OP_READ, OP_MUL_NX, OP_MUL_NY,
        OP_MUL_UK, OP_DIV_D, OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        S_LOAD, S_DRAIN, S_NSXY, S_SXSY, S_NSXX, S_SXSX, S_DIV_K, S_KK,
        S_SQRT, S_DEN, S_READ, S_NX, S_NY, S_UK, S_DIV_D, S_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic go;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic degen;
        logic last_pt;
        logic pipe_busy;
    } t_stat;

endpackage

@@ design/lfs_mul.sv @@
// Sequential 64 by 64 multiplier, product modulo 2^64, from 32 by 32 partial products.
module lfs_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    import lfs_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_pp;
    logic [63:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            case (r_cnt)
                2'd0: r_pp <= r_a[31:0] * r_b[31:0];
                2'd1: begin
                    r_acc <= r_pp;
                    r_pp  <= r_a[31:0] * r_b[63:32];
                end
                2'd2: begin
                    r_acc <= r_acc + {r_pp[31:0], 32'd0};
                    r_pp  <= r_a[63:32] * r_b[31:0];
                end
                default: r_acc <= r_acc + {r_pp[31:0], 32'd0};
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

@@ design/lfs_div.sv @@
// Restoring divider: round(num * 2^fb / den) half away from zero, capped at 2^62.
module lfs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [63:0]                  i_num,
    input  logic [63:0]                  i_den,
    input  logic [lfs_pkg::DIV_FB_W-1:0] i_fb,
    output logic                         o_done,
    output logic [63:0]                  o_q
);
    import lfs_pkg::*;

    logic                 r_busy;
    logic                 r_fin;
    logic                 r_done;
    logic [6:0]           r_cnt;
    logic [6:0]           r_steps;
    logic [63:0]          r_den;
    logic [63:0]          r_rem;
    logic [DIV_EXT_W-1:0] r_dvd;
    logic [DIV_EXT_W-1:0] r_q;
    logic [63:0]          r_res;

    logic [64:0] rem_sh;
    logic [64:0] rem_diff;
    logic        take;
    logic        cap;
    logic        half;

    assign rem_sh   = {r_rem, r_dvd[DIV_EXT_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign take     = rem_sh >= {1'b0, r_den};
    assign cap      = (r_q[DIV_EXT_W-1:62] != '0) || (r_den == 64'd0);
    assign half     = r_rem >= (r_den - r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == r_steps - 7'd1) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den   <= i_den;
            r_rem   <= 64'd0;
            r_dvd   <= {i_num, 16'd0};
            r_q     <= '0;
            r_steps <= 7'd64 + 7'(i_fb);
        end else if (r_busy) begin
            r_rem <= take ? rem_diff[63:0] : rem_sh[63:0];
            r_dvd <= {r_dvd[DIV_EXT_W-2:0], 1'b0};
            r_q   <= {r_q[DIV_EXT_W-2:0], take};
        end else if (r_fin) begin
            r_res <= cap ? (64'd1 << 62) : (r_q[63:0] + 64'(half));
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;
endmodule

@@ design/lfs_dp.sv @@
// Datapath: point store, sums, shared multiplier and divider, square root, result registers.
module lfs_dp #(
    parameter int MAX_POINTS = lfs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = lfs_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lfs_pkg::t_cmd                i_cmd,
    output lfs_pkg::t_stat               o_stat,
    input  logic                         i_acc,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    output logic                         o_valid,
    output logic signed [31:0]           o_slope,
    output logic [30:0]                  o_pos_dev,
    output logic signed [31:0]           o_neg_dev,
    output logic [31:0]                  o_total_dev,
    output logic [1:0]                   o_status
);
    import lfs_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = COORD_BITS + CNT_W;

    logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
    logic [COORD_BITS-1:0] y_mem [MAX_POINTS];

    logic [CNT_W-1:0]              r_cnt;
    logic                          r_drop;
    logic signed [SUM_W-1:0]       r_sx;
    logic signed [SUM_W-1:0]       r_sy;
    logic [63:0]                   r_sxx;
    logic [63:0]                   r_sxy;
    logic                          r_s1_v;
    logic                          r_s2_v;
    logic signed [COORD_BITS-1:0]  r_px;
    logic signed [COORD_BITS-1:0]  r_py;
    logic signed [2*COORD_BITS-1:0] r_pxx;
    logic signed [2*COORD_BITS-1:0] r_pxy;

    t_op                          r_op;
    logic                         r_done;
    logic                         r_lastp;
    logic [IDX_W-1:0]             r_idx;
    logic signed [COORD_BITS-1:0] r_xq;
    logic signed [COORD_BITS-1:0] r_yq;
    logic [63:0] r_t1, r_a, r_b, r_r, r_den, r_u, r_v, r_p;
    logic signed [31:0]           r_kq;
    logic [30:0]                  r_pos;
    logic [31:0]                  r_negm;

    logic        r_sq_busy;
    logic        r_sq_fin;
    logic [4:0]  r_sq_cnt;
    logic [63:0] r_sq_rem, r_sq_res, r_sq_bit;

    logic                r_valid;
    logic signed [31:0]  r_slope;
    logic [30:0]         r_pos_dev;
    logic signed [31:0]  r_neg_dev;
    logic [31:0]         r_total_dev;
    logic [1:0]          r_status;

    logic        wr_en;
    logic        go;
    logic        mul_start, div_start;
    logic [63:0] mul_a, mul_b, mul_p;
    logic        mul_done;
    logic [63:0] div_num, div_den, div_q;
    logic [DIV_FB_W-1:0] div_fb;
    logic        div_done;
    logic [63:0] n64, sx64, sy64, kq64, a_mag, p_mag, sq_t;
    logic        degen;
    logic [32:0] tot;

    assign go    = i_cmd.go;
    assign wr_en = i_acc && (r_cnt < CNT_W'(MAX_POINTS));
    assign n64   = 64'(r_cnt);
    assign sx64  = 64'(r_sx);
    assign sy64  = 64'(r_sy);
    assign kq64  = 64'(r_kq);
    assign a_mag = r_a[63] ? (64'd0 - r_a) : r_a;
    assign p_mag = r_p[63] ? (64'd0 - r_p) : r_p;
    assign sq_t  = r_sq_res + r_sq_bit;
    assign degen = (r_cnt < CNT_W'(2)) || r_b[63] || (r_b == 64'd0);
    assign tot   = {2'b00, r_pos} + {1'b0, r_negm};

    // operand selection for the shared units, sampled on the issue beat
    always_comb begin
        mul_start = 1'b0;
        mul_a     = 64'd0;
        mul_b     = 64'd0;
        div_start = 1'b0;
        div_num   = a_mag;
        div_den   = r_b;
        div_fb    = DIV_FB_W'(DIV_FB_SLOPE);
        case (i_cmd.op)
            OP_MUL_NSXY: begin mul_start = go; mul_a = n64;  mul_b = r_sxy; end
            OP_MUL_SXSY: begin mul_start = go; mul_a = sx64; mul_b = sy64;  end
            OP_MUL_NSXX: begin mul_start = go; mul_a = n64;  mul_b = r_sxx; end
            OP_MUL_SXSX: begin mul_start = go; mul_a = sx64; mul_b = sx64;  end
            OP_MUL_KK:   begin mul_start = go; mul_a = kq64; mul_b = kq64;  end
            OP_MUL_DEN:  begin mul_start = go; mul_a = n64;  mul_b = r_r;   end
            OP_MUL_NX:   begin mul_start = go; mul_a = n64;  mul_b = 64'(r_xq); end
            OP_MUL_NY:   begin mul_start = go; mul_a = n64;  mul_b = 64'(r_yq); end
            OP_MUL_UK:   begin mul_start = go; mul_a = r_u;  mul_b = kq64;  end
            OP_DIV_K:    div_start = go;
            OP_DIV_D: begin
                div_start = go;
                div_num   = p_mag;
                div_den   = r_den;
                div_fb    = DIV_FB_W'(DIV_FB_DIST);
            end
            default: ;
        endcase
    end

    lfs_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_prod(mul_p)
    );

    lfs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .i_fb(div_fb),
        .o_done(div_done), .o_q(div_q)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            x_mem[r_cnt[IDX_W-1:0]] <= i_x;
            y_mem[r_cnt[IDX_W-1:0]] <= i_y;
        end
        if (go && i_cmd.op == OP_READ) begin
            r_xq <= x_mem[r_idx];
            r_yq <= y_mem[r_idx];
        end
    end

    // load side: count, sums, and a two-stage product pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_drop <= 1'b0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_sxx  <= 64'd0;
            r_sxy  <= 64'd0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= wr_en;
            r_s2_v <= r_s1_v;
            if (wr_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_sx  <= r_sx + SUM_W'(i_x);
                r_sy  <= r_sy + SUM_W'(i_y);
            end else if (i_acc) begin
                r_drop <= 1'b1;
            end
            if (r_s2_v) begin
                r_sxx <= r_sxx + 64'(r_pxx);
                r_sxy <= r_sxy + 64'(r_pxy);
            end
            if (go && i_cmd.op == OP_OUT) begin
                r_cnt  <= '0;
                r_drop <= 1'b0;
                r_sx   <= '0;
                r_sy   <= '0;
                r_sxx  <= 64'd0;
                r_sxy  <= 64'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_px <= i_x;
            r_py <= i_y;
        end
        if (r_s1_v) begin
            r_pxx <= r_px * r_px;
            r_pxy <= r_px * r_py;
        end
    end

    // fit side: command completion and result write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op      <= OP_NONE;
            r_done    <= 1'b0;
            r_lastp   <= 1'b0;
            r_idx     <= '0;
            r_kq      <= '0;
            r_pos     <= '0;
            r_negm    <= '0;
            r_sq_busy <= 1'b0;
            r_sq_fin  <= 1'b0;
            r_sq_cnt  <= 5'd0;
            r_valid   <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_valid  <= 1'b0;
            r_sq_fin <= 1'b0;
            if (go) begin
                r_op <= i_cmd.op;
            end
            if (go && i_cmd.op == OP_READ) begin
                r_done <= 1'b1;
            end
            if (go && i_cmd.op == OP_SQRT) begin
                r_sq_busy <= 1'b1;
                r_sq_cnt  <= 5'd0;
                r_sq_rem  <= r_t1;
                r_sq_res  <= 64'd0;
                r_sq_bit  <= 64'd1 << 62;
            end else if (r_sq_busy) begin
                if (r_sq_rem >= sq_t) begin
                    r_sq_rem <= r_sq_rem - sq_t;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_sq_cnt <= r_sq_cnt + 5'd1;
                if (r_sq_cnt == 5'd31) begin
                    r_sq_busy <= 1'b0;
                    r_sq_fin  <= 1'b1;
                end
            end else if (r_sq_fin) begin
                r_r    <= r_sq_res + 64'(r_sq_rem > r_sq_res);
                r_done <= 1'b1;
            end
            if (mul_done) begin
                r_done <= 1'b1;
                case (r_op)
                    OP_MUL_NSXY, OP_MUL_NSXX: r_t1 <= mul_p;
                    OP_MUL_SXSY: r_a   <= r_t1 - mul_p;
                    OP_MUL_SXSX: r_b   <= r_t1 - mul_p;
                    OP_MUL_KK:   r_t1  <= mul_p + (64'd1 << 32);
                    OP_MUL_DEN:  r_den <= mul_p;
                    OP_MUL_NX:   r_u   <= mul_p - sx64;
                    OP_MUL_NY:   r_v   <= mul_p - sy64;
                    OP_MUL_UK:   r_p   <= mul_p - (r_v << 16);
                    default: ;
                endcase
            end
            if (div_done) begin
                r_done <= 1'b1;
                if (r_op == OP_DIV_K) begin
                    if (r_a[63]) begin
                        r_kq <= (div_q > 64'h8000_0000) ? 32'sh8000_0000 :
                                (32'd0 - div_q[31:0]);
                    end else begin
                        r_kq <= (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q[31:0];
                    end
                end else begin
                    r_lastp <= (CNT_W'(r_idx) == r_cnt - CNT_W'(1));
                    r_idx   <= r_idx + IDX_W'(1);
                    if (!r_p[63] && r_p != 64'd0) begin
                        if (((div_q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : div_q[30:0]) > r_pos) begin
                            r_pos <= (div_q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : div_q[30:0];
                        end
                    end else if (r_p[63]) begin
                        if (((div_q > 64'h8000_0000) ? 32'h8000_0000 : div_q[31:0]) > r_negm) begin
                            r_negm <= (div_q > 64'h8000_0000) ? 32'h8000_0000 : div_q[31:0];
                        end
                    end
                end
            end
            if (go && i_cmd.op == OP_OUT) begin
                r_done      <= 1'b1;
                r_valid     <= 1'b1;
                r_slope     <= r_kq;
                r_pos_dev   <= r_pos;
                r_neg_dev   <= 32'd0 - r_negm;
                r_total_dev <= tot[32] ? 32'hFFFF_FFFF : tot[31:0];
                r_status    <= degen ? ST_DEGEN : (r_drop ? ST_DROP : ST_OK);
                r_kq        <= '0;
                r_pos       <= '0;
                r_negm      <= '0;
                r_idx       <= '0;
            end
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.degen     = degen;
    assign o_stat.last_pt   = r_lastp;
    assign o_stat.pipe_busy = r_s1_v | r_s2_v;

    assign o_valid     = r_valid;
    assign o_slope     = r_slope;
    assign o_pos_dev   = r_pos_dev;
    assign o_neg_dev   = r_neg_dev;
    assign o_total_dev = r_total_dev;
    assign o_status    = r_status;
endmodule

@@ design/lfs_ctrl.sv @@
// Controller: sequences the fit steps and the per-point pass over the store.
module lfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc_last,
    input  lfs_pkg::t_stat i_stat,
    output lfs_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import lfs_pkg::*;

    t_state r_state, n_state;
    logic   r_issued, n_issued;
    logic   work;
    t_op    op;
    t_state nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_issued  = r_issued;
        o_cmd.op  = OP_NONE;
        o_cmd.go  = 1'b0;
        o_busy    = 1'b1;
        work      = 1'b1;
        op        = OP_NONE;
        nxt       = S_LOAD;
        unique case (r_state)
            S_LOAD: begin
                work   = 1'b0;
                o_busy = 1'b0;
                if (i_acc_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                work = 1'b0;
                if (!i_stat.pipe_busy) n_state = S_NSXY;
            end
            S_NSXY: begin op = OP_MUL_NSXY; nxt = S_SXSY; end
            S_SXSY: begin op = OP_MUL_SXSY; nxt = S_NSXX; end
            S_NSXX: begin op = OP_MUL_NSXX; nxt = S_SXSX; end
            S_SXSX: begin op = OP_MUL_SXSX; nxt = S_DIV_K; end
            S_DIV_K: begin
                op  = OP_DIV_K;
                nxt = S_KK;
                // skip the rest of the fit on a degenerate set
                if (i_stat.degen && !r_issued) begin
                    work    = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_KK:    begin op = OP_MUL_KK;  nxt = S_SQRT; end
            S_SQRT:  begin op = OP_SQRT;    nxt = S_DEN;  end
            S_DEN:   begin op = OP_MUL_DEN; nxt = S_READ; end
            S_READ:  begin op = OP_READ;    nxt = S_NX;   end
            S_NX:    begin op = OP_MUL_NX;  nxt = S_NY;   end
            S_NY:    begin op = OP_MUL_NY;  nxt = S_UK;   end
            S_UK:    begin op = OP_MUL_UK;  nxt = S_DIV_D; end
            S_DIV_D: begin
                op  = OP_DIV_D;
                nxt = i_stat.last_pt ? S_OUT : S_READ;
            end
            S_OUT:   begin op = OP_OUT;     nxt = S_LOAD; end
        endcase
        if (work) begin
            o_cmd.op = op;
            if (!r_issued) begin
                o_cmd.go = 1'b1;
                n_issued = 1'b1;
            end else if (i_stat.done) begin
                n_issued = 1'b0;
                n_state  = nxt;
            end
        end
    end
endmodule

@@ design/line_fit_straightness.sv @@
// Top level of the least-squares line fit and straightness block.
//
// Points enter on i_x_coord / i_y_coord / i_last. A beat is taken at a rising
// edge with start high and busy low. While loading, busy stays low and one
// point is taken every cycle. The beat with i_last set is stored too and
// starts the fit; busy then stays high until the result is shown.
// Points past MAX_POINTS are dropped and reported through status.
// The result appears for exactly one cycle with o_valid high; the receiver
// cannot stall it, so it must take the beat in that cycle.
// After the last point the fit runs its setup (pipeline drain, four 64-bit
// products of the shared multiplier, an 80-step slope division, the slope
// square, a 32-step square root and the n*R product), then a pass over each
// stored point of three multiplier passes and a division in the shared
// restoring divider (72 steps), and finally shows the result.
// A degenerate set skips the point pass and all fit steps after the four products.
// busy drops the cycle after o_valid is shown, so the next set may load then.
// Reset clears counts, sums and the controller; the point store needs no
// clearing since only entries written for the current set are read.
module line_fit_straightness #(
    parameter int MAX_POINTS = lfs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = lfs_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_x_coord,
    input  logic signed [COORD_BITS-1:0] i_y_coord,
    input  logic                         i_last,
    output logic                         o_valid,
    output logic signed [31:0]           o_slope,
    output logic signed [31:0]           o_intercept,
    output logic [30:0]                  o_pos_dev,
    output logic signed [31:0]           o_neg_dev,
    output logic [31:0]                  o_total_dev,
    output logic [1:0]                   o_status
);
    import lfs_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  acc;

    // take a beat only while the controller is loading
    assign acc = start && !busy;

    lfs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc_last(acc && i_last),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    lfs_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_acc(acc), .i_x(i_x_coord), .i_y(i_y_coord),
        .o_valid(o_valid), .o_slope(o_slope), .o_pos_dev(o_pos_dev),
        .o_neg_dev(o_neg_dev), .o_total_dev(o_total_dev), .o_status(o_status)
    );

    // the centered frame puts the intercept at zero
    assign o_intercept = 32'sd0;

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> busy) else $error("no fit after last point");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_DEGEN || o_status == ST_DROP))
        else $error("bad status code");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DEGEN) |-> (o_slope == 32'sd0 && o_total_dev == 32'd0))
        else $error("degenerate result not zero");
endmodule
